@@ design/cab_pkg.sv @@
// ----------------------------------------------------------------------------
// cab_pkg
// Shared types and constants for the CSR adjacency builder: payload structs,
// command and status codes, and the controller/datapath command interface.
// ----------------------------------------------------------------------------
package cab_pkg;

  // Default sizes
  localparam int unsigned DEF_MAX_VERTICES = 1024;
  localparam int unsigned DEF_MAX_EDGES    = 4096;
  localparam int unsigned DEF_WEIGHT_BITS  = 32;

  // Vertex count after reset
  localparam logic [10:0] VERTEX_COUNT_RESET = 11'd1024;

  // Request command codes
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QDEG  = 2'd2,
    CMD_QEDGE = 2'd3
  } command_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_VERTEX_RANGE   = 3'd1,
    ST_POSITION_RANGE = 3'd2,
    ST_STORE_FULL     = 3'd3,
    ST_NOT_BUILT      = 3'd4
  } status_t;

  // Request payload
  typedef struct packed {
    logic [1:0]         command;
    logic [9:0]         edge_source;
    logic [9:0]         edge_target;
    logic signed [31:0] edge_weight_in;
    logic [9:0]         query_vertex;
    logic [12:0]        query_position;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic [2:0]         status;
    logic [13:0]        degree;
    logic [9:0]         result_source;
    logic [9:0]         result_target;
    logic signed [31:0] result_weight;
  } out_item_t;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_SET_STATUS,
    OP_ADD_STORE,
    OP_INC_SRC,
    OP_READ_DST,
    OP_INC_DST,
    OP_BUILD_INIT,
    OP_PRE_READ,
    OP_PRE_WRITE,
    OP_SC_READ_SRC,
    OP_SC_WRITE_SRC,
    OP_SC_READ_DST,
    OP_SC_WRITE_DST,
    OP_SET_BUILT,
    OP_QUERY_READ,
    OP_DEGREE_TAKE,
    OP_EDGE_CHECK,
    OP_EDGE_TAKE,
    OP_EMIT
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       src_ok;
    logic       dst_ok;
    logic       full;
    logic       qv_ok;
    logic       built;
    logic       pos_bad;
    logic       cnt_last;
    logic       edge_done;
    logic       out_busy;
  } dp_stat_t;

endpackage

@@ design/csr_adjacency_builder.sv @@
// ----------------------------------------------------------------------------
// csr_adjacency_builder
// Builds the compressed sparse row adjacency of an undirected weighted graph
// by counting sort; answers degree and incident-edge queries.
// ----------------------------------------------------------------------------
// An add checks range and capacity, stores the edge and bumps both degrees;
// a request refused at dispatch or an edge query past the degree goes straight
// to its result. Build runs a prefix sum over the vertices, then scatters each
// edge through its source and target cursors. One request is in work at a
// time; the next is taken while a result waits. After reset a clearing pass
// zeroes the degree memory; configuration writes are taken as ever.
// ----------------------------------------------------------------------------
module csr_adjacency_builder
  import cab_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned MAX_EDGES    = DEF_MAX_EDGES,
  parameter int unsigned WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        config_write,
  input  logic [10:0] config_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  cab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  cab_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .config_write (config_write),
    .config_data  (config_data)
  );

endmodule

@@ design/cab_ram.sv @@
// ----------------------------------------------------------------------------
// cab_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/cab_datapath.sv @@
// ----------------------------------------------------------------------------
// cab_datapath
// Storage and arithmetic of the builder: degree, offset, cursor, edge and
// adjacency memories, counters, result and output registers.
// ----------------------------------------------------------------------------
module cab_datapath
  import cab_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned MAX_EDGES    = DEF_MAX_EDGES,
  parameter int unsigned WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        config_write,
  input  logic [10:0] config_data
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);
  localparam int unsigned RW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned AW = $clog2(2 * MAX_EDGES);
  localparam int unsigned DW = $clog2(2 * MAX_EDGES + 1);
  localparam int unsigned XW = 2 * VW + WEIGHT_BITS;
  localparam int unsigned CW = (DW > 13) ? DW : 13;
  localparam logic [10:0] NCAP = 11'((MAX_VERTICES > 2047) ? 2047 : MAX_VERTICES);

  in_item_t        req;
  out_item_t       res;
  logic [10:0]     vc;
  logic [10:0]     n_eff;
  logic [EW-1:0]   edge_total;
  logic [EW-1:0]   eidx;
  logic [VW-1:0]   cnt;
  logic [DW-1:0]   run;
  logic            built;

  logic [VW-1:0]   src_v;
  logic [VW-1:0]   dst_v;
  logic [VW-1:0]   qv_v;

  logic            deg_we;
  logic [VW-1:0]   deg_waddr;
  logic [DW-1:0]   deg_wdata;
  logic [VW-1:0]   deg_raddr;
  logic [DW-1:0]   deg_rdata;

  logic            off_we;
  logic [DW-1:0]   off_rdata;

  logic            pos_we;
  logic [VW-1:0]   pos_waddr;
  logic [VW-1:0]   pos_raddr;
  logic [DW-1:0]   pos_rdata;

  logic            raw_we;
  logic [XW-1:0]   raw_wdata;
  logic [XW-1:0]   raw_rdata;
  logic [VW-1:0]   raw_src;
  logic [VW-1:0]   raw_dst;
  logic [WEIGHT_BITS-1:0] raw_w;

  logic            adj_we;
  logic [XW-1:0]   adj_wdata;
  logic [AW-1:0]   adj_raddr;
  logic [XW-1:0]   adj_rdata;
  logic signed [WEIGHT_BITS-1:0] adj_w;

  // Effective vertex count, saturated into 1..MAX_VERTICES (at most 2047)
  always_comb begin
    if (vc == 11'd0) begin
      n_eff = 11'd1;
    end else if (vc > NCAP) begin
      n_eff = NCAP;
    end else begin
      n_eff = vc;
    end
  end

  assign src_v = VW'(req.edge_source);
  assign dst_v = VW'(req.edge_target);
  assign qv_v  = VW'(req.query_vertex);

  assign raw_src = raw_rdata[XW-1 -: VW];
  assign raw_dst = raw_rdata[WEIGHT_BITS+VW-1 -: VW];
  assign raw_w   = raw_rdata[WEIGHT_BITS-1:0];
  assign adj_w   = adj_rdata[WEIGHT_BITS-1:0];

  // Status back to the controller
  assign stat.command   = req.command;
  assign stat.src_ok    = {1'b0, req.edge_source} < n_eff;
  assign stat.dst_ok    = {1'b0, req.edge_target} < n_eff;
  assign stat.full      = edge_total == EW'(MAX_EDGES);
  assign stat.qv_ok     = {1'b0, req.query_vertex} < n_eff;
  assign stat.built     = built;
  assign stat.pos_bad   = CW'(req.query_position) >= CW'(deg_rdata);
  assign stat.cnt_last  = cnt == VW'(MAX_VERTICES - 1);
  assign stat.edge_done = eidx == edge_total;
  assign stat.out_busy  = out_valid && out_stall;

  // Degree memory ports
  always_comb begin
    deg_we    = 1'b0;
    deg_waddr = cnt;
    deg_wdata = deg_rdata + DW'(1);
    case (cmd.op)
      OP_CLEAR: begin
        deg_we    = 1'b1;
        deg_wdata = '0;
      end
      OP_INC_SRC: begin
        deg_we    = 1'b1;
        deg_waddr = src_v;
      end
      OP_INC_DST: begin
        deg_we    = 1'b1;
        deg_waddr = dst_v;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_ADD_STORE:  deg_raddr = src_v;
      OP_READ_DST:   deg_raddr = dst_v;
      OP_QUERY_READ: deg_raddr = qv_v;
      default:       deg_raddr = cnt;
    endcase
  end

  // Offset and cursor memory ports
  assign off_we    = cmd.op == OP_PRE_WRITE;
  assign pos_we    = (cmd.op == OP_PRE_WRITE) || (cmd.op == OP_SC_WRITE_SRC) ||
                     (cmd.op == OP_SC_WRITE_DST);
  assign pos_raddr = (cmd.op == OP_SC_READ_DST) ? raw_dst : raw_src;

  always_comb begin
    case (cmd.op)
      OP_SC_WRITE_SRC: pos_waddr = raw_src;
      OP_SC_WRITE_DST: pos_waddr = raw_dst;
      default:         pos_waddr = cnt;
    endcase
  end

  // Edge store and adjacency memory ports
  assign raw_we    = cmd.op == OP_ADD_STORE;
  assign raw_wdata = {src_v, dst_v, WEIGHT_BITS'(req.edge_weight_in)};
  assign adj_we    = (cmd.op == OP_SC_WRITE_SRC) || (cmd.op == OP_SC_WRITE_DST);
  assign adj_wdata = (cmd.op == OP_SC_WRITE_DST) ? {raw_dst, raw_src, raw_w} :
                                                   {raw_src, raw_dst, raw_w};
  assign adj_raddr = AW'(CW'(off_rdata) + CW'(req.query_position));

  cab_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_deg (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  cab_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_off (
    .clk   (clk),
    .we    (off_we),
    .waddr (cnt),
    .wdata (run),
    .raddr (qv_v),
    .rdata (off_rdata)
  );

  cab_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_pos (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata ((cmd.op == OP_PRE_WRITE) ? run : DW'(pos_rdata + DW'(1))),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  cab_ram #(.WIDTH(XW), .DEPTH(MAX_EDGES)) u_raw (
    .clk   (clk),
    .we    (raw_we),
    .waddr (RW'(edge_total)),
    .wdata (raw_wdata),
    .raddr (RW'(eidx)),
    .rdata (raw_rdata)
  );

  cab_ram #(.WIDTH(XW), .DEPTH(2 * MAX_EDGES)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (AW'(pos_rdata)),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vc         <= VERTEX_COUNT_RESET;
      edge_total <= '0;
      built      <= 1'b0;
      cnt        <= '0;
      eidx       <= '0;
      run        <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Drop the output once taken
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_CLEAR: begin
          cnt <= cnt + VW'(1);
        end
        OP_ADD_STORE: begin
          edge_total <= edge_total + EW'(1);
          built      <= 1'b0;
        end
        OP_BUILD_INIT: begin
          cnt  <= '0;
          run  <= '0;
          eidx <= '0;
        end
        OP_PRE_WRITE: begin
          cnt <= cnt + VW'(1);
          run <= run + deg_rdata;
        end
        OP_SC_WRITE_DST: begin
          eidx <= eidx + EW'(1);
        end
        OP_SET_BUILT: begin
          built <= 1'b1;
        end
        default: begin
        end
      endcase
      // A register write invalidates the built rows
      if (config_write) begin
        vc    <= config_data;
        built <= 1'b0;
      end
    end
  end

  // Request, result and output payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        req <= in_data;
        res <= '0;
      end
      OP_SET_STATUS: begin
        res.status <= cmd.code;
      end
      OP_DEGREE_TAKE: begin
        res.degree <= 14'(deg_rdata);
      end
      OP_EDGE_CHECK: begin
        res.degree <= 14'(deg_rdata);
        if (stat.pos_bad) begin
          res.status <= ST_POSITION_RANGE;
        end
      end
      OP_EDGE_TAKE: begin
        res.result_source <= 10'(adj_rdata[XW-1 -: VW]);
        res.result_target <= 10'(adj_rdata[WEIGHT_BITS+VW-1 -: VW]);
        res.result_weight <= 32'(adj_w);
      end
      OP_EMIT: begin
        out_data <= res;
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |-> !(out_valid && out_stall))
    else $error("result emitted over a stalled result");

  a_store_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_ADD_STORE |-> !stat.full && stat.src_ok && stat.dst_ok)
    else $error("edge stored while full or out of range");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    edge_total <= EW'(MAX_EDGES))
    else $error("edge total above capacity");

  a_scatter_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_SC_WRITE_SRC |-> eidx < edge_total)
    else $error("scatter past last stored edge");

endmodule

@@ design/cab_ctrl.sv @@
// ----------------------------------------------------------------------------
// cab_ctrl
// Sequencer of the builder: clearing pass, request dispatch, add, build
// (prefix sum and scatter), queries and result hand-off.
// ----------------------------------------------------------------------------
module cab_ctrl
  import cab_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_ADD_SW,
    S_ADD_TR,
    S_ADD_TW,
    S_PRE_RD,
    S_PRE_WR,
    S_SC_RD,
    S_SC_PS,
    S_SC_WS,
    S_SC_PT,
    S_SC_WT,
    S_QD,
    S_QE_CHK,
    S_QE_DATA,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != S_IDLE;

  // Next state and datapath command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.code   = ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.command)
          CMD_ADD: begin
            if (!(stat.src_ok && stat.dst_ok)) begin
              cmd.op     = OP_SET_STATUS;
              cmd.code   = ST_VERTEX_RANGE;
              state_next = S_RESP;
            end else if (stat.full) begin
              cmd.op     = OP_SET_STATUS;
              cmd.code   = ST_STORE_FULL;
              state_next = S_RESP;
            end else begin
              cmd.op     = OP_ADD_STORE;
              state_next = S_ADD_SW;
            end
          end
          CMD_BUILD: begin
            cmd.op     = OP_BUILD_INIT;
            state_next = S_PRE_RD;
          end
          CMD_QDEG: begin
            if (!stat.qv_ok) begin
              cmd.op     = OP_SET_STATUS;
              cmd.code   = ST_VERTEX_RANGE;
              state_next = S_RESP;
            end else begin
              cmd.op     = OP_QUERY_READ;
              state_next = S_QD;
            end
          end
          default: begin
            if (!stat.built) begin
              cmd.op     = OP_SET_STATUS;
              cmd.code   = ST_NOT_BUILT;
              state_next = S_RESP;
            end else if (!stat.qv_ok) begin
              cmd.op     = OP_SET_STATUS;
              cmd.code   = ST_VERTEX_RANGE;
              state_next = S_RESP;
            end else begin
              cmd.op     = OP_QUERY_READ;
              state_next = S_QE_CHK;
            end
          end
        endcase
      end
      S_ADD_SW: begin
        cmd.op     = OP_INC_SRC;
        state_next = S_ADD_TR;
      end
      S_ADD_TR: begin
        cmd.op     = OP_READ_DST;
        state_next = S_ADD_TW;
      end
      S_ADD_TW: begin
        cmd.op     = OP_INC_DST;
        state_next = S_RESP;
      end
      S_PRE_RD: begin
        cmd.op     = OP_PRE_READ;
        state_next = S_PRE_WR;
      end
      S_PRE_WR: begin
        cmd.op     = OP_PRE_WRITE;
        state_next = stat.cnt_last ? S_SC_RD : S_PRE_RD;
      end
      S_SC_RD: begin
        if (stat.edge_done) begin
          cmd.op     = OP_SET_BUILT;
          state_next = S_RESP;
        end else begin
          state_next = S_SC_PS;
        end
      end
      S_SC_PS: begin
        cmd.op     = OP_SC_READ_SRC;
        state_next = S_SC_WS;
      end
      S_SC_WS: begin
        cmd.op     = OP_SC_WRITE_SRC;
        state_next = S_SC_PT;
      end
      S_SC_PT: begin
        cmd.op     = OP_SC_READ_DST;
        state_next = S_SC_WT;
      end
      S_SC_WT: begin
        cmd.op     = OP_SC_WRITE_DST;
        state_next = S_SC_RD;
      end
      S_QD: begin
        cmd.op     = OP_DEGREE_TAKE;
        state_next = S_RESP;
      end
      S_QE_CHK: begin
        cmd.op     = OP_EDGE_CHECK;
        state_next = stat.pos_bad ? S_RESP : S_QE_DATA;
      end
      S_QE_DATA: begin
        cmd.op     = OP_EDGE_TAKE;
        state_next = S_RESP;
      end
      S_RESP: begin
        // Hold until the output register is free
        if (!stat.out_busy) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
